// ----- src/sbus_pkg.sv -----
// Shared constants, types and helpers for the SBUS frame decoder.
package sbus_pkg;

   localparam int FRAME_LEN = 25;
   localparam int ADDR_W    = $clog2(FRAME_LEN);
   localparam int CHANNELS  = 16;
   localparam int CH_W      = 4;
   localparam int VAL_W     = 11;
   localparam int CSR_IDX_W = 4;
   localparam int CSR_DAT_W = 11;

   localparam logic [7:0]        START_BYTE = 8'h0F;
   localparam logic [7:0]        END_BYTE   = 8'h00;
   localparam logic [ADDR_W-1:0] FLAG_POS   = ADDR_W'(23);
   localparam logic [ADDR_W-1:0] LAST_POS   = ADDR_W'(FRAME_LEN - 1);
   localparam logic [CH_W-1:0]   LAST_CH    = CH_W'(CHANNELS - 1);

   localparam int LOST_BIT = 2;
   localparam int FS_BIT   = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_ARM_CHANNEL   = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_ARM_THRESHOLD = CSR_IDX_W'(1);

   localparam logic [CH_W-1:0]  ARM_CHANNEL_RST   = CH_W'(4);
   localparam logic [VAL_W-1:0] ARM_THRESHOLD_RST = VAL_W'(1535);

   typedef enum logic [2:0] {
      ST_COLLECT,
      ST_ARM_GO,
      ST_ARM_WAIT,
      ST_CH_GO,
      ST_CH_WAIT,
      ST_CH_OUT
   } state_type;

   // window fetch request: three bytes from base, value starts at bit off
   typedef struct packed {
      logic              go;
      logic [ADDR_W-1:0] base;
      logic [2:0]        off;
   } fetch_req_type;

   typedef struct packed {
      logic             done;
      logic [VAL_W-1:0] value;
   } fetch_rsp_type;

   // bit offset of a channel inside the packed payload (ch * 11)
   function automatic logic [7:0] chan_bitpos(input logic [CH_W-1:0] ch);
      logic [7:0] c;
      c = 8'(ch);
      return (c << 3) + (c << 1) + c;
   endfunction

endpackage

// ----- src/sbus_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module sbus_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 25,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/sbus_fetch.sv -----
// Reads a three-byte window from the frame RAM and extracts one 11-bit channel.
module sbus_fetch (
   input  logic                              clock,
   input  logic                              reset,
   input  sbus_pkg::fetch_req_type           req,
   output logic                              rd_en,
   output logic [sbus_pkg::ADDR_W-1:0]       rd_addr,
   input  logic [7:0]                        rd_data,
   output sbus_pkg::fetch_rsp_type           rsp
);

   logic                             busy_ff, busy_in;
   logic [1:0]                       issue_ff, issue_in;
   logic [sbus_pkg::ADDR_W-1:0]      base_ff, base_in;
   logic [2:0]                       off_ff, off_in;
   logic                             rvalid_ff;
   logic [1:0]                       rlane_ff;
   logic [15:0]                      win_ff, win_in;
   logic                             done_ff, done_in;
   logic [sbus_pkg::VAL_W-1:0]       value_ff, value_in;
   logic [23:0]                      full_win;
   logic [23:0]                      shifted;

   always_comb begin
      rd_en    = busy_ff && (issue_ff != 2'd3);
      rd_addr  = base_ff + sbus_pkg::ADDR_W'(issue_ff);
      full_win = {rd_data, win_ff};
      shifted  = full_win >> off_ff;

      busy_in  = busy_ff;
      issue_in = issue_ff;
      base_in  = base_ff;
      off_in   = off_ff;
      win_in   = win_ff;
      done_in  = 1'b0;
      value_in = value_ff;

      if (req.go) begin
         busy_in  = 1'b1;
         issue_in = 2'd0;
         base_in  = req.base;
         off_in   = req.off;
      end else if (rd_en) begin
         issue_in = issue_ff + 2'd1;
      end

      // read data returns in the cycle after the address; lane tells which byte
      if (rvalid_ff) begin
         case (rlane_ff)
            2'd0: begin
               win_in[7:0] = rd_data;
            end
            2'd1: begin
               win_in[15:8] = rd_data;
            end
            default: begin
               done_in  = 1'b1;
               value_in = shifted[sbus_pkg::VAL_W-1:0];
               busy_in  = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= 1'b0;
         issue_ff  <= 2'd0;
         rvalid_ff <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         busy_ff   <= busy_in;
         issue_ff  <= issue_in;
         rvalid_ff <= rd_en;
         done_ff   <= done_in;
      end
      base_ff  <= base_in;
      off_ff   <= off_in;
      rlane_ff <= issue_ff;
      win_ff   <= win_in;
      value_ff <= value_in;
   end

   assign rsp.done  = done_ff;
   assign rsp.value = value_ff;

endmodule

// ----- src/sbus_frame_decoder_unit.sv -----
// Top level of the SBUS frame decoder: byte collection, decode sequencer, result register.
//
// Usage:
//  req_*  : one received serial byte per transaction (req_rx_byte).
//  rsp_*  : one transaction per decoded channel, 16 per good frame, in channel
//           order; rsp_last marks channel 15.
//  csr_*  : register writes, index 0 = arm_channel, 1 = arm_threshold; always
//           ready, other indexes are dropped.
// While collecting, a byte is taken every cycle. Bytes are parked in a 25-entry
// frame RAM. Once the 25th byte arrives and it is 0x00, req_ready drops and the
// sequencer decodes: the arm channel window is read first to settle the armed
// flag, then each channel window. The RAM has one read port, so every channel
// costs three reads; req_ready rises again once the last channel result is
// loaded. A bad end byte drops the frame with no output and collection resumes
// in the next cycle.
// The result register decouples the receiver: the next channel window is
// fetched while a result waits, and the sequencer holds if rsp_ready stays low;
// a result held past that lengthens the frame.
// Reset (synchronous) returns to start-byte search, clears the frame count and
// loads arm_channel = 4, arm_threshold = 1535. The frame RAM is not cleared;
// every entry read is written earlier in the same frame.
module sbus_frame_decoder_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [7:0]                          req_rx_byte,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [sbus_pkg::CH_W-1:0]           rsp_channel_index,
   output logic [sbus_pkg::VAL_W-1:0]          rsp_channel_value,
   output logic                                rsp_lost_flag,
   output logic                                rsp_failsafe,
   output logic [31:0]                         rsp_frame_number,
   output logic                                rsp_armed,
   output logic                                rsp_last,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [sbus_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [sbus_pkg::CSR_DAT_W-1:0]      csr_wdata
);

   sbus_pkg::state_type               state_ff, state_in;
   logic [sbus_pkg::ADDR_W-1:0]       pos_ff, pos_in;
   logic [31:0]                       good_frames_ff, good_frames_in;
   logic [sbus_pkg::CH_W-1:0]         arm_channel_ff, arm_channel_in;
   logic [sbus_pkg::VAL_W-1:0]        arm_threshold_ff, arm_threshold_in;
   logic                              lost_ff, lost_in;
   logic                              fs_ff, fs_in;
   logic                              armed_ff, armed_in;
   logic [sbus_pkg::CH_W-1:0]         ch_ff, ch_in;
   logic [sbus_pkg::VAL_W-1:0]        chval_ff, chval_in;

   logic                              rsp_valid_ff, rsp_valid_in;
   logic [sbus_pkg::CH_W-1:0]         rsp_index_ff, rsp_index_in;
   logic [sbus_pkg::VAL_W-1:0]        rsp_value_ff, rsp_value_in;
   logic                              rsp_lost_ff, rsp_lost_in;
   logic                              rsp_fs_ff, rsp_fs_in;
   logic [31:0]                       rsp_frame_ff, rsp_frame_in;
   logic                              rsp_armed_ff, rsp_armed_in;
   logic                              rsp_last_ff, rsp_last_in;

   logic                              req_fire;
   logic                              good_end;
   logic                              out_free;
   logic                              load_out;
   logic [sbus_pkg::CH_W-1:0]         sel_ch;
   logic [7:0]                        bitpos;

   logic                              ram_wr_en;
   logic                              ram_rd_en;
   logic [sbus_pkg::ADDR_W-1:0]       ram_rd_addr;
   logic [7:0]                        ram_rd_data;
   sbus_pkg::fetch_req_type           fetch_req;
   sbus_pkg::fetch_rsp_type           fetch_rsp;

   // frame storage; collection and decode never overlap, so no forwarding
   sbus_ram #(
      .WIDTH (8),
      .DEPTH (sbus_pkg::FRAME_LEN)
   ) u_frame_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (pos_ff),
      .wr_data (req_rx_byte),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   sbus_fetch u_fetch (
      .clock   (clock),
      .reset   (reset),
      .req     (fetch_req),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data),
      .rsp     (fetch_rsp)
   );

   assign req_fire = req_valid && req_ready;
   assign good_end = req_fire && (pos_ff == sbus_pkg::LAST_POS)
                     && (req_rx_byte == sbus_pkg::END_BYTE);
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign csr_ready = 1'b1;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sbus_pkg::ST_COLLECT: begin
            if (good_end) begin
               state_in = sbus_pkg::ST_ARM_GO;
            end
         end
         sbus_pkg::ST_ARM_GO: begin
            state_in = sbus_pkg::ST_ARM_WAIT;
         end
         sbus_pkg::ST_ARM_WAIT: begin
            if (fetch_rsp.done) begin
               state_in = sbus_pkg::ST_CH_GO;
            end
         end
         sbus_pkg::ST_CH_GO: begin
            state_in = sbus_pkg::ST_CH_WAIT;
         end
         sbus_pkg::ST_CH_WAIT: begin
            if (fetch_rsp.done) begin
               state_in = sbus_pkg::ST_CH_OUT;
            end
         end
         sbus_pkg::ST_CH_OUT: begin
            if (out_free) begin
               state_in = (ch_ff == sbus_pkg::LAST_CH) ? sbus_pkg::ST_COLLECT
                                                       : sbus_pkg::ST_CH_GO;
            end
         end
         default: begin
            state_in = sbus_pkg::ST_COLLECT;
         end
      endcase
   end

   // state outputs
   always_comb begin
      req_ready      = 1'b0;
      fetch_req.go   = 1'b0;
      load_out       = 1'b0;
      sel_ch         = ch_ff;
      case (state_ff)
         sbus_pkg::ST_COLLECT: begin
            req_ready = 1'b1;
         end
         sbus_pkg::ST_ARM_GO: begin
            fetch_req.go = 1'b1;
            sel_ch       = arm_channel_ff;
         end
         sbus_pkg::ST_CH_GO: begin
            fetch_req.go = 1'b1;
         end
         sbus_pkg::ST_CH_OUT: begin
            load_out = out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
      bitpos         = sbus_pkg::chan_bitpos(sel_ch);
      fetch_req.base = sbus_pkg::ADDR_W'(bitpos[7:3]) + sbus_pkg::ADDR_W'(1);
      fetch_req.off  = bitpos[2:0];
   end

   // datapath next values
   always_comb begin
      pos_in           = pos_ff;
      good_frames_in   = good_frames_ff;
      arm_channel_in   = arm_channel_ff;
      arm_threshold_in = arm_threshold_ff;
      lost_in          = lost_ff;
      fs_in            = fs_ff;
      armed_in         = armed_ff;
      ch_in            = ch_ff;
      chval_in         = chval_ff;
      ram_wr_en        = 1'b0;

      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_index_in = rsp_index_ff;
      rsp_value_in = rsp_value_ff;
      rsp_lost_in  = rsp_lost_ff;
      rsp_fs_in    = rsp_fs_ff;
      rsp_frame_in = rsp_frame_ff;
      rsp_armed_in = rsp_armed_ff;
      rsp_last_in  = rsp_last_ff;

      if (csr_valid && csr_ready) begin
         if (csr_index == sbus_pkg::CSR_ARM_CHANNEL) begin
            arm_channel_in = csr_wdata[sbus_pkg::CH_W-1:0];
         end else if (csr_index == sbus_pkg::CSR_ARM_THRESHOLD) begin
            arm_threshold_in = csr_wdata;
         end
      end

      // byte collection: hunt for start byte, then fill the frame
      if (req_fire) begin
         if (pos_ff == '0) begin
            if (req_rx_byte == sbus_pkg::START_BYTE) begin
               ram_wr_en = 1'b1;
               pos_in    = sbus_pkg::ADDR_W'(1);
            end
         end else begin
            ram_wr_en = 1'b1;
            if (pos_ff == sbus_pkg::FLAG_POS) begin
               lost_in = req_rx_byte[sbus_pkg::LOST_BIT];
               fs_in   = req_rx_byte[sbus_pkg::FS_BIT];
            end
            if (pos_ff >= sbus_pkg::LAST_POS) begin
               pos_in = '0;
            end else begin
               pos_in = pos_ff + sbus_pkg::ADDR_W'(1);
            end
         end
      end

      if (good_end) begin
         good_frames_in = good_frames_ff + 32'd1;
         ch_in          = '0;
      end

      if (fetch_rsp.done) begin
         if (state_ff == sbus_pkg::ST_ARM_WAIT) begin
            armed_in = fetch_rsp.value > arm_threshold_ff;
         end else begin
            chval_in = fetch_rsp.value;
         end
      end

      if (load_out) begin
         rsp_valid_in = 1'b1;
         rsp_index_in = ch_ff;
         rsp_value_in = chval_ff;
         rsp_lost_in  = lost_ff;
         rsp_fs_in    = fs_ff;
         rsp_frame_in = good_frames_ff;
         rsp_armed_in = armed_ff;
         rsp_last_in  = (ch_ff == sbus_pkg::LAST_CH);
         ch_in        = ch_ff + sbus_pkg::CH_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= sbus_pkg::ST_COLLECT;
         pos_ff           <= '0;
         good_frames_ff   <= '0;
         arm_channel_ff   <= sbus_pkg::ARM_CHANNEL_RST;
         arm_threshold_ff <= sbus_pkg::ARM_THRESHOLD_RST;
         ch_ff            <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         pos_ff           <= pos_in;
         good_frames_ff   <= good_frames_in;
         arm_channel_ff   <= arm_channel_in;
         arm_threshold_ff <= arm_threshold_in;
         ch_ff            <= ch_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
      lost_ff      <= lost_in;
      fs_ff        <= fs_in;
      armed_ff     <= armed_in;
      chval_ff     <= chval_in;
      rsp_index_ff <= rsp_index_in;
      rsp_value_ff <= rsp_value_in;
      rsp_lost_ff  <= rsp_lost_in;
      rsp_fs_ff    <= rsp_fs_in;
      rsp_frame_ff <= rsp_frame_in;
      rsp_armed_ff <= rsp_armed_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_channel_index = rsp_index_ff;
   assign rsp_channel_value = rsp_value_ff;
   assign rsp_lost_flag     = rsp_lost_ff;
   assign rsp_failsafe      = rsp_fs_ff;
   assign rsp_frame_number  = rsp_frame_ff;
   assign rsp_armed         = rsp_armed_ff;
   assign rsp_last          = rsp_last_ff;

   // RAM is never read while bytes are being collected
   a_no_read_in_collect: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !ram_rd_en)
      else $error("frame RAM read during collection");

   // window results only arrive while the sequencer waits for them
   a_done_when_waiting: assert property (@(posedge clock) disable iff (reset)
      fetch_rsp.done |-> (state_ff == sbus_pkg::ST_ARM_WAIT ||
                          state_ff == sbus_pkg::ST_CH_WAIT))
      else $error("unexpected fetch completion");

   // a new result appears only from the output state
   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !$past(rsp_valid_ff && !rsp_ready)) |->
         $past(state_ff == sbus_pkg::ST_CH_OUT))
      else $error("result loaded outside output state");

   // last result of a frame sends the sequencer back to byte collection
   a_last_returns: assert property (@(posedge clock) disable iff (reset)
      (load_out && ch_ff == sbus_pkg::LAST_CH) |=>
         (state_ff == sbus_pkg::ST_COLLECT && rsp_last_ff))
      else $error("frame end not followed by collection");

endmodule

// ----- sim/sbus_frame_decoder_unit_tb.sv -----
// Self-checking testbench for sbus_frame_decoder_unit: byte stream in, checked channel results out.

localparam int PAYLOAD_BYTES = 22;   // 16 channels x 11 bits, packed
localparam int ALL_CH        = 16;   // channels always decoded, emitted or not

typedef struct packed {
   logic [sbus_pkg::CH_W-1:0]  ch_index;
   logic [sbus_pkg::VAL_W-1:0] ch_value;
   logic                       lost_flag;
   logic                       failsafe;
   logic [31:0]                frame_number;
   logic                       armed;
   logic                       last;
} channel_result_type;

// Tracks the decoder's byte collection and queues the channel results it owes.
class sbus_channel_scoreboard;
   logic [7:0]                 frame_buf [sbus_pkg::FRAME_LEN];
   int                         fill;
   logic [31:0]                good_count;
   logic [sbus_pkg::CH_W-1:0]  arm_ch;
   logic [sbus_pkg::VAL_W-1:0] arm_thr;
   channel_result_type         expected_channels [$];
   int                         errors;

   function new();
      fill       = 0;
      good_count = '0;
      arm_ch     = sbus_pkg::ARM_CHANNEL_RST;
      arm_thr    = sbus_pkg::ARM_THRESHOLD_RST;
      errors     = 0;
   endfunction

   function int pending();
      return expected_channels.size();
   endfunction

   function void write_reg(logic [sbus_pkg::CSR_IDX_W-1:0] idx,
                           logic [sbus_pkg::CSR_DAT_W-1:0] data);
      if (idx == sbus_pkg::CSR_ARM_CHANNEL)
         arm_ch = data[sbus_pkg::CH_W-1:0];
      else if (idx == sbus_pkg::CSR_ARM_THRESHOLD)
         arm_thr = data[sbus_pkg::VAL_W-1:0];
   endfunction

   // one accepted rx byte; a good end byte queues one result per channel
   function void note_byte(logic [7:0] rx);
      logic [8*PAYLOAD_BYTES-1:0] payload;
      logic [sbus_pkg::VAL_W-1:0] chan [ALL_CH];
      logic                       is_armed;
      channel_result_type         r;
      if (fill == 0) begin
         if (rx == sbus_pkg::START_BYTE) begin
            frame_buf[0] = rx;
            fill = 1;
         end
         return;
      end
      frame_buf[fill] = rx;
      fill++;
      if (fill < sbus_pkg::FRAME_LEN)
         return;
      fill = 0;
      if (frame_buf[sbus_pkg::FRAME_LEN-1] != sbus_pkg::END_BYTE)
         return;
      for (int i = 0; i < PAYLOAD_BYTES; i++)
         payload[8*i +: 8] = frame_buf[i+1];
      for (int k = 0; k < ALL_CH; k++)
         chan[k] = payload[sbus_pkg::VAL_W*k +: sbus_pkg::VAL_W];
      good_count = good_count + 1;
      is_armed = chan[arm_ch] > arm_thr;
      for (int k = 0; k < sbus_pkg::CHANNELS; k++) begin
         r.ch_index     = sbus_pkg::CH_W'(k);
         r.ch_value     = chan[k];
         r.lost_flag    = frame_buf[sbus_pkg::FLAG_POS][sbus_pkg::LOST_BIT];
         r.failsafe     = frame_buf[sbus_pkg::FLAG_POS][sbus_pkg::FS_BIT];
         r.frame_number = good_count;
         r.armed        = is_armed;
         r.last         = (k == sbus_pkg::CHANNELS - 1);
         expected_channels.push_back(r);
      end
   endfunction

   function void field_check(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
         errors++;
      end
   endfunction

   function void check_channel(channel_result_type got);
      channel_result_type want;
      if (expected_channels.size() == 0) begin
         $display("%0t: unexpected result, expected none, actual channel %0d value %0d",
                  $time, got.ch_index, got.ch_value);
         errors++;
         return;
      end
      want = expected_channels.pop_front();
      field_check("channel_index", want.ch_index, got.ch_index);
      field_check("channel_value", want.ch_value, got.ch_value);
      field_check("lost_flag", want.lost_flag, got.lost_flag);
      field_check("failsafe", want.failsafe, got.failsafe);
      field_check("frame_number", want.frame_number, got.frame_number);
      field_check("armed", want.armed, got.armed);
      field_check("last", want.last, got.last);
   endfunction
endclass

module sbus_frame_decoder_unit_tb;

   localparam int CYCLE_LIMIT  = 200_000;
   // leave margin after a good frame drains, before touching registers and
   // before the final verdict
   localparam int DRAIN_CYCLES = 150;
   localparam int IDLE_PCT     = 21;
   localparam logic [sbus_pkg::CSR_IDX_W-1:0] CSR_IDX_MAX = '1;

   logic                           clock;
   logic                           reset;
   logic                           req_valid;
   logic                           req_ready;
   logic [7:0]                     req_rx_byte;
   logic                           rsp_valid;
   logic                           rsp_ready;
   logic [sbus_pkg::CH_W-1:0]      rsp_channel_index;
   logic [sbus_pkg::VAL_W-1:0]     rsp_channel_value;
   logic                           rsp_lost_flag;
   logic                           rsp_failsafe;
   logic [31:0]                    rsp_frame_number;
   logic                           rsp_armed;
   logic                           rsp_last;
   logic                           csr_valid;
   logic                           csr_ready;
   logic [sbus_pkg::CSR_IDX_W-1:0] csr_index;
   logic [sbus_pkg::CSR_DAT_W-1:0] csr_wdata;

   sbus_channel_scoreboard     sb;
   bit                         steady;             // no idling on either side while set
   logic [sbus_pkg::VAL_W-1:0] chan_vals [ALL_CH]; // channel values of the next frame
   int                         cycle_count;

   sbus_frame_decoder_unit u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_rx_byte       (req_rx_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_channel_index (rsp_channel_index),
      .rsp_channel_value (rsp_channel_value),
      .rsp_lost_flag     (rsp_lost_flag),
      .rsp_failsafe      (rsp_failsafe),
      .rsp_frame_number  (rsp_frame_number),
      .rsp_armed         (rsp_armed),
      .rsp_last          (rsp_last),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   initial clock = 1'b0;
   always #2 clock = ~clock;

   // Receiver back-pressure: random stalls unless in the steady stretch.
   always @(posedge clock) begin
      rsp_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
   end

   // Single monitor for all three channels, so the order of processes at an
   // edge never matters: register writes and bytes are noted, results checked.
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready)
            sb.write_reg(csr_index, csr_wdata);
         if (req_valid && req_ready)
            sb.note_byte(req_rx_byte);
         if (rsp_valid && rsp_ready) begin
            channel_result_type seen;
            seen.ch_index     = rsp_channel_index;
            seen.ch_value     = rsp_channel_value;
            seen.lost_flag    = rsp_lost_flag;
            seen.failsafe     = rsp_failsafe;
            seen.frame_number = rsp_frame_number;
            seen.armed        = rsp_armed;
            seen.last         = rsp_last;
            sb.check_channel(seen);
         end
      end
   end

   // Watchdog: a hung handshake ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("sbus_frame_decoder_unit_tb failed");
         $finish;
      end
   end

   // One byte transaction. Valid is left high on return so that a following
   // byte can go out back to back; it is only dropped when an idle cycle is
   // picked, or by the caller before a pause.
   task automatic send_byte(input logic [7:0] rx);
      while (!steady && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= rx;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
   endtask

   // Start byte, 22 payload bytes packed LSB first from chan_vals, flag byte,
   // end byte.
   task automatic send_frame(input logic [7:0] flags, input logic [7:0] end_byte);
      logic [8*PAYLOAD_BYTES-1:0] payload;
      for (int k = 0; k < ALL_CH; k++)
         payload[sbus_pkg::VAL_W*k +: sbus_pkg::VAL_W] = chan_vals[k];
      send_byte(sbus_pkg::START_BYTE);
      for (int i = 0; i < PAYLOAD_BYTES; i++)
         send_byte(payload[8*i +: 8]);
      send_byte(flags);
      send_byte(end_byte);
   endtask

   task automatic csr_write(input logic [sbus_pkg::CSR_IDX_W-1:0] idx,
                            input logic [sbus_pkg::CSR_DAT_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Quiesce: stop sending so the last byte is noted, let every owed result drain,
   // then add margin.
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Mostly well-formed frames with random content; some noise between
   // frames and about a quarter with a bad end byte.
   task automatic run_phase(input int seqs, input bit force_bad);
      logic [7:0] noise;
      bit         bad;
      for (int s = 0; s < seqs; s++) begin
         // idle-time noise; the start byte is kept out so framing stays intact
         repeat ($urandom_range(2)) begin
            noise = 8'($urandom_range(255));
            if (noise == sbus_pkg::START_BYTE)
               noise = ~noise;
            send_byte(noise);
         end
         // bias values toward the extremes and the armed boundary
         for (int k = 0; k < ALL_CH; k++)
            case ($urandom_range(4))
               0:       chan_vals[k] = '0;
               1:       chan_vals[k] = '1;
               2:       chan_vals[k] = sb.arm_thr;
               3:       chan_vals[k] = sb.arm_thr + 1'b1;
               default: chan_vals[k] = sbus_pkg::VAL_W'($urandom);
            endcase
         bad = (force_bad && s == 0) || ($urandom_range(99) < 25);
         send_frame(8'($urandom_range(255)),
                    bad ? 8'($urandom_range(1, 255)) : sbus_pkg::END_BYTE);
      end
   endtask

   initial begin
      logic [sbus_pkg::CSR_DAT_W-1:0] cfg;
      sb          = new();
      cycle_count = 0;
      steady      = 1'b0;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_rx_byte = '0;
      rsp_ready   = 1'b0;
      csr_valid   = 1'b0;
      csr_index   = '0;
      csr_wdata   = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed: idle noise, then one frame at reset settings. Channel 0
      // packs to a start-byte value inside the frame, channels alternate
      // between full scale and zero, the arm channel sits just above the
      // reset threshold, and both flags are set.
      send_byte(8'h00);
      send_byte(8'hFF);
      for (int k = 0; k < ALL_CH; k++)
         chan_vals[k] = (k % 2) ? '1 : '0;
      chan_vals[0]                         = sbus_pkg::VAL_W'(sbus_pkg::START_BYTE);
      chan_vals[sbus_pkg::ARM_CHANNEL_RST] = sbus_pkg::ARM_THRESHOLD_RST + 1'b1;
      chan_vals[ALL_CH-1]                  = sbus_pkg::ARM_THRESHOLD_RST;
      send_frame(8'hFF, sbus_pkg::END_BYTE);

      // Random phases, each under its own register setting. The first one
      // opens with a bad end byte to check that the decoder resyncs.
      for (int p = 0; p < 4; p++) begin
         if (p > 0) begin
            settle();
            case (p)
               1: begin   // lowest arm channel, threshold zero
                  cfg = sbus_pkg::CSR_DAT_W'($urandom);
                  cfg[sbus_pkg::CH_W-1:0] = '0;
                  csr_write(sbus_pkg::CSR_ARM_CHANNEL, cfg);
                  csr_write(sbus_pkg::CSR_ARM_THRESHOLD, '0);
               end
               2: begin   // highest arm channel, full-scale threshold
                  cfg = sbus_pkg::CSR_DAT_W'($urandom);
                  cfg[sbus_pkg::CH_W-1:0] = '1;
                  csr_write(sbus_pkg::CSR_ARM_CHANNEL, cfg);
                  csr_write(sbus_pkg::CSR_ARM_THRESHOLD, '1);
               end
               default: begin
                  csr_write(sbus_pkg::CSR_ARM_CHANNEL, sbus_pkg::CSR_DAT_W'($urandom));
                  csr_write(sbus_pkg::CSR_ARM_THRESHOLD, sbus_pkg::CSR_DAT_W'($urandom));
               end
            endcase
            // unmapped index: must leave both registers alone
            csr_write(sbus_pkg::CSR_IDX_W'($urandom_range(sbus_pkg::CSR_ARM_THRESHOLD + 1,
                                                           CSR_IDX_MAX)),
                      sbus_pkg::CSR_DAT_W'($urandom));
         end
         steady = (p == 2);
         run_phase(p[0] ? 1 : 2, p == 0);
      end
      steady = 1'b0;

      settle();
      if (sb.errors == 0 && sb.pending() == 0)
         $display("sbus_frame_decoder_unit_tb passed");
      else
         $display("sbus_frame_decoder_unit_tb failed");
      $finish;
   end

endmodule
